// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pixel pair combiner.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pixel_pair_scale_combine: assertion failed");

// Checked on every rising clock edge, reset included.
`define PPS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pixel_pair_scale_combine: reset check failed");

`endif

// File: rtl/pps_pkg.sv
// Shared types, widths and register codes of the pixel pair combiner.
// No dependencies; used by pps_div and pixel_pair_scale_combine.
package pps_pkg;

  // Field and datapath widths
  localparam int IGNORE_SLOTS = 4;
  localparam int PIX_W        = 16;
  localparam int SCALE_W      = 16;
  localparam int FRAC_W       = 12;
  localparam int OOFS_W       = 17;
  localparam int CNT_W        = 3;
  localparam int TABLE_W      = IGNORE_SLOTS * PIX_W;
  localparam int DIFF_W       = PIX_W + 1;           // pixel minus offset
  localparam int TERM_W       = SCALE_W + DIFF_W;    // scaled pixel, Q.12
  localparam int COMB_W       = TERM_W + 1;          // sum or difference of terms
  localparam int DEN_W        = COMB_W - 1;          // magnitude of the sum
  localparam int NUM_SHIFT    = FRAC_W + 1;          // 2 * 2^12
  localparam int NUM_W        = 48;                  // dividend magnitude
  localparam int DIV_BITS     = 4;                   // quotient bits per stage
  localparam int DIV_STAGES   = NUM_W / DIV_BITS;
  localparam int QUOT_W       = NUM_W + 1;           // signed quotient
  localparam int PROD_W       = SCALE_W + QUOT_W;    // Q.24 product
  localparam int ACC_W        = PROD_W + 1;          // product plus offset
  localparam int OUT_SHIFT    = 2 * FRAC_W;
  localparam int ROUND_W      = PIX_W + OUT_SHIFT;

  // 65535 in Q.24, top of the clamp range
  localparam logic signed [ACC_W-1:0] ACC_LIMIT =
    {{(ACC_W-ROUND_W){1'b0}}, {PIX_W{1'b1}}, {OUT_SHIFT{1'b0}}};
  // one half in Q.24, for rounding
  localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(1) << (OUT_SHIFT - 1);

  // Register port
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NORMALIZE_MODE = 3'd0,
    REG_FIRST_SCALE    = 3'd1,
    REG_SECOND_SCALE   = 3'd2,
    REG_OUTPUT_SCALE   = 3'd3,
    REG_INPUT_OFFSET   = 3'd4,
    REG_OUTPUT_OFFSET  = 3'd5,
    REG_IGNORE_COUNT   = 3'd6,
    REG_IGNORE_TABLE   = 3'd7
  } reg_idx_t;

  // Reset values
  localparam logic [SCALE_W-1:0] SCALE_ONE    = SCALE_W'(4096);
  localparam logic [PIX_W-1:0]   IN_OFS_RST   = PIX_W'(40);
  localparam logic [OOFS_W-1:0]  OUT_OFS_RST  = OOFS_W'(40);

  // Input word
  typedef struct packed {
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
  } pair_t;

  // Output word
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             underflow;
    logic             overflow;
    logic             ignored;
  } result_t;

  // Fields that ride along with the divider
  typedef struct packed {
    logic signed [COMB_W-1:0] sum;
    logic                     ignored;
    logic [PIX_W-1:0]         ign_pix;
  } div_side_t;

endpackage

// File: rtl/pps_div.sv
// Pipelined signed divider: (numer * 2^13) / denom, truncated toward zero.
// Uses pps_pkg; one prep stage and DIV_STAGES restoring-division stages.
module pps_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pps_pkg::COMB_W-1:0] numer,
  input  logic signed [pps_pkg::COMB_W-1:0] denom,
  input  pps_pkg::div_side_t                side_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pps_pkg::QUOT_W-1:0] quot,
  output logic                              div_zero,
  output pps_pkg::div_side_t                side_out
);

  // Prep stage: magnitudes and quotient sign
  logic                          p_valid;
  logic                          p_ready;
  logic [pps_pkg::NUM_W-1:0]     p_num;
  logic [pps_pkg::DEN_W-1:0]     p_den;
  logic                          p_neg;
  logic                          p_zero;
  pps_pkg::div_side_t            p_side;

  logic [pps_pkg::COMB_W-1:0]    numer_abs;
  logic [pps_pkg::COMB_W-1:0]    denom_abs;

  // Division stages
  logic                          s_valid [pps_pkg::DIV_STAGES];
  logic                          s_ready [pps_pkg::DIV_STAGES];
  logic [pps_pkg::DEN_W-1:0]     s_rem   [pps_pkg::DIV_STAGES];
  logic [pps_pkg::NUM_W-1:0]     s_nq    [pps_pkg::DIV_STAGES];
  logic [pps_pkg::DEN_W-1:0]     s_den   [pps_pkg::DIV_STAGES];
  logic                          s_neg   [pps_pkg::DIV_STAGES];
  logic                          s_zero  [pps_pkg::DIV_STAGES];
  pps_pkg::div_side_t            s_side  [pps_pkg::DIV_STAGES];

  // Upstream view of each stage
  logic                          up_valid [pps_pkg::DIV_STAGES];
  logic [pps_pkg::DEN_W-1:0]     up_rem   [pps_pkg::DIV_STAGES];
  logic [pps_pkg::NUM_W-1:0]     up_nq    [pps_pkg::DIV_STAGES];
  logic [pps_pkg::DEN_W-1:0]     up_den   [pps_pkg::DIV_STAGES];
  logic                          up_neg   [pps_pkg::DIV_STAGES];
  logic                          up_zero  [pps_pkg::DIV_STAGES];
  pps_pkg::div_side_t            up_side  [pps_pkg::DIV_STAGES];

  // Results of each stage's steps
  logic [pps_pkg::DEN_W-1:0]     step_rem [pps_pkg::DIV_STAGES];
  logic [pps_pkg::NUM_W-1:0]     step_nq  [pps_pkg::DIV_STAGES];

  logic [pps_pkg::QUOT_W-1:0]    quot_mag;

  localparam int LAST = pps_pkg::DIV_STAGES - 1;

  // Absolute values of the operands
  assign numer_abs = numer[pps_pkg::COMB_W-1] ? -numer : numer;
  assign denom_abs = denom[pps_pkg::COMB_W-1] ? -denom : denom;

  assign p_ready  = !p_valid || s_ready[0];
  assign in_ready = p_ready;

  // Stage wiring and ready chain
  for (genvar k = 0; k < pps_pkg::DIV_STAGES; k++) begin : g_link
    if (k == 0) begin : g_first
      assign up_valid[k] = p_valid;
      assign up_rem[k]   = '0;
      assign up_nq[k]    = p_num;
      assign up_den[k]   = p_den;
      assign up_neg[k]   = p_neg;
      assign up_zero[k]  = p_zero;
      assign up_side[k]  = p_side;
    end else begin : g_next
      assign up_valid[k] = s_valid[k-1];
      assign up_rem[k]   = s_rem[k-1];
      assign up_nq[k]    = s_nq[k-1];
      assign up_den[k]   = s_den[k-1];
      assign up_neg[k]   = s_neg[k-1];
      assign up_zero[k]  = s_zero[k-1];
      assign up_side[k]  = s_side[k-1];
    end
    if (k == LAST) begin : g_tail
      assign s_ready[k] = !s_valid[k] || out_ready;
    end else begin : g_body
      assign s_ready[k] = !s_valid[k] || s_ready[k+1];
    end
  end

  // Restoring division: DIV_BITS steps per stage; dividend bits shift out
  // at the top of nq while quotient bits shift in at the bottom
  always_comb begin
    logic [pps_pkg::DEN_W-1:0] rem_w;
    logic [pps_pkg::NUM_W-1:0] nq_w;
    logic [pps_pkg::DEN_W:0]   trial;
    logic [pps_pkg::DEN_W:0]   delta;
    for (int k = 0; k < pps_pkg::DIV_STAGES; k++) begin
      rem_w = up_rem[k];
      nq_w  = up_nq[k];
      for (int i = 0; i < pps_pkg::DIV_BITS; i++) begin
        trial = {rem_w, nq_w[pps_pkg::NUM_W-1]};
        delta = trial - {1'b0, up_den[k]};
        if (trial >= {1'b0, up_den[k]}) begin
          rem_w = delta[pps_pkg::DEN_W-1:0];
          nq_w  = {nq_w[pps_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_w = trial[pps_pkg::DEN_W-1:0];
          nq_w  = {nq_w[pps_pkg::NUM_W-2:0], 1'b0};
        end
      end
      step_rem[k] = rem_w;
      step_nq[k]  = nq_w;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      for (int k = 0; k < pps_pkg::DIV_STAGES; k++) begin
        s_valid[k] <= 1'b0;
      end
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      for (int k = 0; k < pps_pkg::DIV_STAGES; k++) begin
        if (s_ready[k]) begin
          s_valid[k] <= up_valid[k];
        end
      end
    end
    if (p_ready && in_valid) begin
      p_num  <= pps_pkg::NUM_W'({numer_abs[pps_pkg::DEN_W-1:0],
                                 {pps_pkg::NUM_SHIFT{1'b0}}});
      p_den  <= denom_abs[pps_pkg::DEN_W-1:0];
      p_neg  <= numer[pps_pkg::COMB_W-1] ^ denom[pps_pkg::COMB_W-1];
      p_zero <= (denom == '0);
      p_side <= side_in;
    end
    for (int k = 0; k < pps_pkg::DIV_STAGES; k++) begin
      if (s_ready[k] && up_valid[k]) begin
        s_rem[k]  <= step_rem[k];
        s_nq[k]   <= step_nq[k];
        s_den[k]  <= up_den[k];
        s_neg[k]  <= up_neg[k];
        s_zero[k] <= up_zero[k];
        s_side[k] <= up_side[k];
      end
    end
  end

  // Signed quotient out of the last stage
  assign quot_mag  = {1'b0, s_nq[LAST]};
  assign quot      = s_neg[LAST] ? -quot_mag : quot_mag;
  assign div_zero  = s_zero[LAST];
  assign side_out  = s_side[LAST];
  assign out_valid = s_valid[LAST];

endmodule

// File: rtl/pixel_pair_scale_combine.sv
// Pixel pair combiner: scaled sum or normalized difference of two pixels.
// Throughput: one word per cycle unless result_ready stalls it; the pipelined divider
// has 12 stages of 4 quotient bits each, which every word passes in both modes.
// Reset: synchronous rst empties the pipeline and loads register defaults.
// Depends on pps_pkg, pps_div and assert_macros.svh.
`include "assert_macros.svh"

module pixel_pair_scale_combine (
  input  logic                         clk,
  input  logic                         rst,
  // pixel pair channel
  input  logic                         pair_valid,
  output logic                         pair_ready,
  input  pps_pkg::pair_t               pair,
  // result channel
  output logic                         result_valid,
  input  logic                         result_ready,
  output pps_pkg::result_t             result,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pps_pkg::ADDR_W-1:0]   paddr,
  input  logic [pps_pkg::DATA_W-1:0]   pwdata,
  output logic [pps_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // Configuration registers
  logic                             normalize_mode;
  logic [pps_pkg::SCALE_W-1:0]      first_scale;
  logic [pps_pkg::SCALE_W-1:0]      second_scale;
  logic [pps_pkg::SCALE_W-1:0]      output_scale;
  logic [pps_pkg::PIX_W-1:0]        input_offset;
  logic [pps_pkg::OOFS_W-1:0]       output_offset;
  logic [pps_pkg::CNT_W-1:0]        ignore_count;
  logic [pps_pkg::TABLE_W-1:0]      ignore_table;

  pps_pkg::reg_idx_t                reg_idx;
  logic                             reg_write;

  // Ignore matching
  logic [pps_pkg::CNT_W-1:0]        slots_on;
  logic                             ign_hit;
  logic [pps_pkg::PIX_W-1:0]        ign_val;

  // Stage A: offset removed
  logic                             a_valid;
  logic                             a_ready;
  logic signed [pps_pkg::DIFF_W-1:0] a_da;
  logic signed [pps_pkg::DIFF_W-1:0] a_db;
  logic                             a_ign;
  logic [pps_pkg::PIX_W-1:0]        a_ival;

  // Stage B: scaled terms
  logic                             b_valid;
  logic                             b_ready;
  logic signed [pps_pkg::TERM_W-1:0] b_ta;
  logic signed [pps_pkg::TERM_W-1:0] b_tb;
  logic                             b_ign;
  logic [pps_pkg::PIX_W-1:0]        b_ival;

  // Stage C: sum and difference
  logic                             c_valid;
  logic                             c_ready;
  logic signed [pps_pkg::COMB_W-1:0] c_sum;
  logic signed [pps_pkg::COMB_W-1:0] c_diff;
  logic                             c_ign;
  logic [pps_pkg::PIX_W-1:0]        c_ival;
  pps_pkg::div_side_t               c_side;

  // Divider
  logic                             div_in_ready;
  logic                             div_out_valid;
  logic signed [pps_pkg::QUOT_W-1:0] div_quot;
  logic                             div_zero;
  pps_pkg::div_side_t               div_side;

  // Stage N: multiplier operand
  logic                             n_valid;
  logic                             n_ready;
  logic signed [pps_pkg::QUOT_W-1:0] n_op;
  logic                             n_zero;
  logic                             n_ign;
  logic [pps_pkg::PIX_W-1:0]        n_ival;

  // Stage M: product, Q.24
  logic                             m_valid;
  logic                             m_ready;
  logic signed [pps_pkg::PROD_W-1:0] m_v;
  logic                             m_zero;
  logic                             m_ign;
  logic [pps_pkg::PIX_W-1:0]        m_ival;

  // Stage G: output offset added
  logic                             g_valid;
  logic                             g_ready;
  logic signed [pps_pkg::ACC_W-1:0] g_acc;
  logic                             g_zero;
  logic                             g_ign;
  logic [pps_pkg::PIX_W-1:0]        g_ival;

  // Output register
  logic                             f_ready;
  logic                             f_under;
  logic                             f_over;
  logic [pps_pkg::ROUND_W-1:0]      f_round;
  pps_pkg::result_t                 result_next;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = pps_pkg::reg_idx_t'(
                       paddr[pps_pkg::ADDR_W-1:pps_pkg::ADDR_W-pps_pkg::REG_IDX_W]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_mode <= 1'b0;
      first_scale    <= pps_pkg::SCALE_ONE;
      second_scale   <= pps_pkg::SCALE_ONE;
      output_scale   <= pps_pkg::SCALE_ONE;
      input_offset   <= pps_pkg::IN_OFS_RST;
      output_offset  <= pps_pkg::OUT_OFS_RST;
      ignore_count   <= '0;
      ignore_table   <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        pps_pkg::REG_NORMALIZE_MODE: normalize_mode <= pwdata[0];
        pps_pkg::REG_FIRST_SCALE:    first_scale    <= pwdata[pps_pkg::SCALE_W-1:0];
        pps_pkg::REG_SECOND_SCALE:   second_scale   <= pwdata[pps_pkg::SCALE_W-1:0];
        pps_pkg::REG_OUTPUT_SCALE:   output_scale   <= pwdata[pps_pkg::SCALE_W-1:0];
        pps_pkg::REG_INPUT_OFFSET:   input_offset   <= pwdata[pps_pkg::PIX_W-1:0];
        pps_pkg::REG_OUTPUT_OFFSET:  output_offset  <= pwdata[pps_pkg::OOFS_W-1:0];
        pps_pkg::REG_IGNORE_COUNT:   ignore_count   <= pwdata[pps_pkg::CNT_W-1:0];
        pps_pkg::REG_IGNORE_TABLE:   ignore_table   <= pwdata[pps_pkg::TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      pps_pkg::REG_NORMALIZE_MODE: prdata = pps_pkg::DATA_W'(normalize_mode);
      pps_pkg::REG_FIRST_SCALE:    prdata = pps_pkg::DATA_W'(first_scale);
      pps_pkg::REG_SECOND_SCALE:   prdata = pps_pkg::DATA_W'(second_scale);
      pps_pkg::REG_OUTPUT_SCALE:   prdata = pps_pkg::DATA_W'(output_scale);
      pps_pkg::REG_INPUT_OFFSET:   prdata = pps_pkg::DATA_W'(input_offset);
      pps_pkg::REG_OUTPUT_OFFSET:  prdata = pps_pkg::DATA_W'(output_offset);
      pps_pkg::REG_IGNORE_COUNT:   prdata = pps_pkg::DATA_W'(ignore_count);
      pps_pkg::REG_IGNORE_TABLE:   prdata = pps_pkg::DATA_W'(ignore_table);
      default:                     prdata = '0;
    endcase
  end

  // Ready chain, output side first
  assign f_ready    = !result_valid || result_ready;
  assign g_ready    = !g_valid || f_ready;
  assign m_ready    = !m_valid || g_ready;
  assign n_ready    = !n_valid || m_ready;
  assign c_ready    = !c_valid || div_in_ready;
  assign b_ready    = !b_valid || c_ready;
  assign a_ready    = !a_valid || b_ready;
  assign pair_ready = a_ready;

  // Ignore slots: count above the slot total enables all; lowest slot wins
  assign slots_on = (ignore_count > pps_pkg::CNT_W'(pps_pkg::IGNORE_SLOTS)) ?
                    pps_pkg::CNT_W'(pps_pkg::IGNORE_SLOTS) : ignore_count;

  always_comb begin
    ign_hit = 1'b0;
    ign_val = '0;
    for (int k = pps_pkg::IGNORE_SLOTS - 1; k >= 0; k--) begin
      if ((pps_pkg::CNT_W'(k) < slots_on) &&
          ((pair.pixel_a == ignore_table[k*pps_pkg::PIX_W +: pps_pkg::PIX_W]) ||
           (pair.pixel_b == ignore_table[k*pps_pkg::PIX_W +: pps_pkg::PIX_W]))) begin
        ign_hit = 1'b1;
        ign_val = ignore_table[k*pps_pkg::PIX_W +: pps_pkg::PIX_W];
      end
    end
  end

  // Stages A, B, C valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= pair_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  // Stage A: subtract input offset, resolve ignore match
  always_ff @(posedge clk) begin
    if (a_ready && pair_valid) begin
      a_da   <= $signed({1'b0, pair.pixel_a}) - $signed({1'b0, input_offset});
      a_db   <= $signed({1'b0, pair.pixel_b}) - $signed({1'b0, input_offset});
      a_ign  <= ign_hit;
      a_ival <= ign_val;
    end
  end

  // Stage B: per-image scale
  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_ta   <= pps_pkg::TERM_W'($signed(first_scale)) * pps_pkg::TERM_W'(a_da);
      b_tb   <= pps_pkg::TERM_W'($signed(second_scale)) * pps_pkg::TERM_W'(a_db);
      b_ign  <= a_ign;
      b_ival <= a_ival;
    end
  end

  // Stage C: sum and difference of terms
  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_sum  <= pps_pkg::COMB_W'(b_ta) + pps_pkg::COMB_W'(b_tb);
      c_diff <= pps_pkg::COMB_W'(b_ta) - pps_pkg::COMB_W'(b_tb);
      c_ign  <= b_ign;
      c_ival <= b_ival;
    end
  end

  assign c_side.sum     = c_sum;
  assign c_side.ignored = c_ign;
  assign c_side.ign_pix = c_ival;

  // Quotient 2*diff/sum in Q.12
  pps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (div_in_ready),
    .numer     (c_diff),
    .denom     (c_sum),
    .side_in   (c_side),
    .out_valid (div_out_valid),
    .out_ready (n_ready),
    .quot      (div_quot),
    .div_zero  (div_zero),
    .side_out  (div_side)
  );

  // Stages N, M, G and output valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid      <= 1'b0;
      m_valid      <= 1'b0;
      g_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (n_ready) n_valid      <= div_out_valid;
      if (m_ready) m_valid      <= n_valid;
      if (g_ready) g_valid      <= m_valid;
      if (f_ready) result_valid <= g_valid;
    end
  end

  // Stage N: pick quotient or plain sum
  always_ff @(posedge clk) begin
    if (n_ready && div_out_valid) begin
      n_op   <= normalize_mode ? div_quot : pps_pkg::QUOT_W'($signed(div_side.sum));
      n_zero <= normalize_mode && div_zero;
      n_ign  <= div_side.ignored;
      n_ival <= div_side.ign_pix;
    end
  end

  // Stage M: output scale
  always_ff @(posedge clk) begin
    if (m_ready && n_valid) begin
      m_v    <= pps_pkg::PROD_W'($signed(output_scale)) * pps_pkg::PROD_W'(n_op);
      m_zero <= n_zero;
      m_ign  <= n_ign;
      m_ival <= n_ival;
    end
  end

  // Stage G: output offset in Q.24
  always_ff @(posedge clk) begin
    if (g_ready && m_valid) begin
      g_acc  <= pps_pkg::ACC_W'(m_v) +
                (pps_pkg::ACC_W'($signed(output_offset)) <<< pps_pkg::OUT_SHIFT);
      g_zero <= m_zero;
      g_ign  <= m_ign;
      g_ival <= m_ival;
    end
  end

  // Clamp, round half up, apply zero-sum and ignore overrides
  assign f_under = g_acc[pps_pkg::ACC_W-1];
  assign f_over  = g_acc > pps_pkg::ACC_LIMIT;
  assign f_round = g_acc[pps_pkg::ROUND_W-1:0] + pps_pkg::ROUND_HALF;

  always_comb begin
    if (g_zero) begin
      result_next.pixel_out = '1;
      result_next.underflow = 1'b0;
      result_next.overflow  = 1'b1;
    end else begin
      result_next.underflow = f_under;
      result_next.overflow  = f_over;
      if (f_under) begin
        result_next.pixel_out = '0;
      end else if (f_over) begin
        result_next.pixel_out = '1;
      end else begin
        result_next.pixel_out = f_round[pps_pkg::ROUND_W-1:pps_pkg::OUT_SHIFT];
      end
    end
    result_next.ignored = g_ign;
    if (g_ign) begin
      result_next.pixel_out = g_ival;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (f_ready && g_valid) begin
      result <= result_next;
    end
  end

  // Checks
  `PPS_ASSERT(a_accept_fills, pair_valid && pair_ready |=> a_valid)
  `PPS_ASSERT(a_stall_only_full, !pair_ready |-> a_valid)
  `PPS_ASSERT(a_flags_exclusive, result_valid |-> !(result.underflow && result.overflow))
  `PPS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid)

endmodule

// File: test/pps_result_check.sv
// Result checker for the pixel pair combiner: follows register writes, predicts each
// output word from the accepted pair words and compares field by field.
// Depends on pps_pkg for the word types, widths and register codes.
`timescale 1ns / 1ps

module pps_result_check
  import pps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  input  logic                pair_ready,
  input  pair_t               pair,
  input  logic                result_valid,
  input  logic                result_ready,
  input  result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  in_flight,
  output int                  words_checked,
  output int                  ignored_seen,
  output int                  clamped_seen
);

  localparam longint Q12_UNIT = 64'sd1 << FRAC_W;
  localparam longint Q24_UNIT = 64'sd1 << OUT_SHIFT;
  localparam longint Q24_HALF = Q24_UNIT / 2;
  localparam longint PIX_TOP  = 64'sd65535;

  // Shadow copy of the register file
  logic                      cfg_norm;
  logic signed [SCALE_W-1:0] cfg_first;
  logic signed [SCALE_W-1:0] cfg_second;
  logic signed [SCALE_W-1:0] cfg_out_scale;
  logic [PIX_W-1:0]          cfg_in_ofs;
  logic signed [OOFS_W-1:0]  cfg_out_ofs;
  logic [CNT_W-1:0]          cfg_ign_count;
  logic [TABLE_W-1:0]        cfg_ign_table;

  result_t expected_pixels[$];
  result_t want;

  // Expected output word for one pixel pair under the current registers
  function automatic result_t combine_pixel(pair_t p);
    longint  ta;
    longint  tb;
    longint  den;
    longint  quot;
    longint  v;
    result_t r;
    int      n;
    int      k;
    logic [PIX_W-1:0] slot;
    bit      zero_den;
    r        = '0;
    v        = 0;
    zero_den = 1'b0;
    ta = longint'(cfg_first) * (longint'(p.pixel_a) - longint'(cfg_in_ofs));
    tb = longint'(cfg_second) * (longint'(p.pixel_b) - longint'(cfg_in_ofs));
    if (cfg_norm) begin
      den = ta + tb;
      if (den == 0) begin
        zero_den = 1'b1;
      end else begin
        // truncates toward zero, Q.12
        quot = (2 * (ta - tb) * Q12_UNIT) / den;
        v    = longint'(cfg_out_scale) * quot;
      end
    end else begin
      v = longint'(cfg_out_scale) * (ta + tb);
    end
    if (zero_den) begin
      // zero sum saturates high regardless of the output pedestal
      r.pixel_out = '1;
      r.overflow  = 1'b1;
    end else begin
      v = v + longint'(cfg_out_ofs) * Q24_UNIT;
      if (v < 0) begin
        r.underflow = 1'b1;
        v = 0;
      end
      if (v > PIX_TOP * Q24_UNIT) begin
        r.overflow = 1'b1;
        v = PIX_TOP * Q24_UNIT;
      end
      r.pixel_out = PIX_W'((v + Q24_HALF) >>> OUT_SHIFT);
    end
    // lowest enabled slot wins; counts past the slot count enable all slots
    n = (cfg_ign_count > IGNORE_SLOTS) ? IGNORE_SLOTS : int'(cfg_ign_count);
    for (k = 0; k < n && !r.ignored; k++) begin
      slot = cfg_ign_table[PIX_W*k +: PIX_W];
      if (p.pixel_a == slot || p.pixel_b == slot) begin
        r.pixel_out = slot;
        r.ignored   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [PIX_W-1:0] want_v,
                             input logic [PIX_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Channel and register port monitor
  always @(posedge clk) begin
    if (rst) begin
      cfg_norm      = 1'b0;
      cfg_first     = SCALE_ONE;
      cfg_second    = SCALE_ONE;
      cfg_out_scale = SCALE_ONE;
      cfg_in_ofs    = IN_OFS_RST;
      cfg_out_ofs   = OUT_OFS_RST;
      cfg_ign_count = '0;
      cfg_ign_table = '0;
      expected_pixels.delete();
      fail_count    = 0;
      words_checked = 0;
      ignored_seen  = 0;
      clamped_seen  = 0;
    end else begin
      // predict with the registers in force before this edge
      if (pair_valid && pair_ready) begin
        expected_pixels.push_back(combine_pixel(pair));
      end
      if (result_valid && result_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with none expected: pixel_out %0d", result.pixel_out);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_out", want.pixel_out, result.pixel_out);
          check_field("underflow", want.underflow, result.underflow);
          check_field("overflow", want.overflow, result.overflow);
          check_field("ignored", want.ignored, result.ignored);
          words_checked++;
          if (want.ignored) ignored_seen++;
          if (want.underflow || want.overflow) clamped_seen++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_NORMALIZE_MODE: cfg_norm      = pwdata[0];
          REG_FIRST_SCALE:    cfg_first     = pwdata[SCALE_W-1:0];
          REG_SECOND_SCALE:   cfg_second    = pwdata[SCALE_W-1:0];
          REG_OUTPUT_SCALE:   cfg_out_scale = pwdata[SCALE_W-1:0];
          REG_INPUT_OFFSET:   cfg_in_ofs    = pwdata[PIX_W-1:0];
          REG_OUTPUT_OFFSET:  cfg_out_ofs   = pwdata[OOFS_W-1:0];
          REG_IGNORE_COUNT:   cfg_ign_count = pwdata[CNT_W-1:0];
          REG_IGNORE_TABLE:   cfg_ign_table = pwdata[TABLE_W-1:0];
          default: ;
        endcase
      end
    end
    in_flight = expected_pixels.size();
  end

endmodule

// File: test/pixel_pair_scale_combine_tb.sv
// Testbench top for pixel_pair_scale_combine: clock, reset, pair words, register
// writes and the verdict. Depends on pps_pkg, the RTL and pps_result_check.
`timescale 1ns / 1ps

module pixel_pair_scale_combine_tb;
  import pps_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 25;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_WORDS  = 50;

  typedef struct packed {
    logic                      mode;
    logic signed [SCALE_W-1:0] first;
    logic signed [SCALE_W-1:0] second;
    logic signed [SCALE_W-1:0] out_scale;
    logic [PIX_W-1:0]          in_ofs;
    logic signed [OOFS_W-1:0]  out_ofs;
    logic [CNT_W-1:0]          ign_count;
    logic [TABLE_W-1:0]        ign_table;
  } combine_cfg_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                pair_valid   = 1'b0;
  logic                pair_ready;
  pair_t               pair         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_count;
  int in_flight;
  int words_checked;
  int ignored_seen;
  int clamped_seen;
  int settings_used = 0;
  bit steady        = 1'b0;   // no idling on either side while set
  combine_cfg_t cur_cfg;

  always #(CLK_PERIOD / 2) clk = ~clk;

  pixel_pair_scale_combine u_top (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .pair         (pair),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  pps_result_check u_checker (
    .clk           (clk),
    .rst           (rst),
    .pair_valid    (pair_valid),
    .pair_ready    (pair_ready),
    .pair          (pair),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .in_flight     (in_flight),
    .words_checked (words_checked),
    .ignored_seen  (ignored_seen),
    .clamped_seen  (clamped_seen)
  );

  // Result side back-pressure
  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 26);
  end

  function automatic combine_cfg_t settings(
    input logic mode, input int first, input int second, input int out_scale,
    input int in_ofs, input int out_ofs, input int ign_count,
    input logic [TABLE_W-1:0] ign_table);
    combine_cfg_t c;
    c.mode      = mode;
    c.first     = SCALE_W'(first);
    c.second    = SCALE_W'(second);
    c.out_scale = SCALE_W'(out_scale);
    c.in_ofs    = PIX_W'(in_ofs);
    c.out_ofs   = OOFS_W'(out_ofs);
    c.ign_count = CNT_W'(ign_count);
    c.ign_table = ign_table;
    return c;
  endfunction

  // Setup then access; psel stays up between back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pair_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  // Registers change only with the pipeline empty
  task automatic apply_settings(input combine_cfg_t c);
    wait_drained();
    write_reg(REG_NORMALIZE_MODE, {63'd0, c.mode});
    write_reg(REG_FIRST_SCALE, {48'd0, c.first});
    write_reg(REG_SECOND_SCALE, {48'd0, c.second});
    write_reg(REG_OUTPUT_SCALE, {48'd0, c.out_scale});
    write_reg(REG_INPUT_OFFSET, {48'd0, c.in_ofs});
    write_reg(REG_OUTPUT_OFFSET, {47'd0, c.out_ofs});
    write_reg(REG_IGNORE_COUNT, {61'd0, c.ign_count});
    write_reg(REG_IGNORE_TABLE, c.ign_table);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // One pair word, with random idle cycles ahead of it
  task automatic send_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    while (!steady && $urandom_range(99) < 26) begin
      pair_valid <= 1'b0;
      @(negedge clk);
    end
    pair_valid <= 1'b1;
    pair       <= {a, b};
    do @(posedge clk); while (!pair_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [SCALE_W-1:0] pick_scale();
    case ($urandom_range(6))
      0: return SCALE_W'(-32768);
      1: return SCALE_W'(32767);
      2: return '0;
      3: return SCALE_ONE;
      4: return SCALE_W'(-4096);
      default: return SCALE_W'($urandom_range(16383) - 8192);
    endcase
  endfunction

  function automatic combine_cfg_t pick_settings();
    combine_cfg_t c;
    c.mode      = 1'($urandom_range(1));
    c.first     = pick_scale();
    c.second    = pick_scale();
    c.out_scale = pick_scale();
    case ($urandom_range(4))
      0: c.in_ofs = '0;
      1: c.in_ofs = '1;
      2: c.in_ofs = PIX_W'($urandom);
      default: c.in_ofs = PIX_W'($urandom_range(2000));
    endcase
    case ($urandom_range(4))
      0: c.out_ofs = OOFS_W'(-65535);
      1: c.out_ofs = OOFS_W'(65535);
      2: c.out_ofs = '0;
      default: c.out_ofs = OOFS_W'($urandom_range(131070) - 65535);
    endcase
    c.ign_count = CNT_W'($urandom_range(7));
    c.ign_table = {$urandom, $urandom};
    return c;
  endfunction

  // Pixels biased toward ignore slots, the pedestal and the range ends
  function automatic logic [PIX_W-1:0] pick_pixel();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return cur_cfg.ign_table[PIX_W*$urandom_range(3) +: PIX_W];
    if (sel < 20) return cur_cfg.in_ofs;
    if (sel < 28) return '0;
    if (sel < 36) return '1;
    if (sel < 60) return cur_cfg.in_ofs + PIX_W'($urandom_range(255)) - PIX_W'(128);
    return PIX_W'($urandom);
  endfunction

  initial begin
    int p;
    int i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cur_cfg = settings(1'b0, 4096, 4096, 4096, 40, 40, 0, '0);
    @(negedge clk);

    // reset registers: plain sum, clamping at both ends
    send_pair(16'd0, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'd40, 16'd40);
    send_pair(16'd0, 16'hFFFF);
    send_pair(16'hFFFF, 16'd0);
    send_pair(16'd1234, 16'd5678);

    // half-scale sum: rounding of exact halves goes up
    apply_settings(settings(1'b0, 2048, 0, 4096, 0, 0, 0, '0));
    send_pair(16'd1, 16'd0);
    send_pair(16'd3, 16'd9);
    send_pair(16'd2, 16'd0);

    // normalize, negative pedestal: zero sums still saturate high
    apply_settings(settings(1'b1, 4096, 4096, 32767, 40, -65535, 0, '0));
    send_pair(16'd40, 16'd40);
    send_pair(16'd50, 16'd30);
    send_pair(16'd100, 16'd40);
    send_pair(16'd40, 16'd100);

    // extreme scales, three slots on: match on either pixel, lowest slot wins
    apply_settings(settings(1'b0, -32768, 32767, -32768, 65535, 65535, 3,
                            {16'hFFFF, 16'd300, 16'd200, 16'd100}));
    send_pair(16'd100, 16'd7);
    send_pair(16'd7, 16'd200);
    send_pair(16'd300, 16'd100);
    send_pair(16'hFFFF, 16'd0);
    send_pair(16'd0, 16'hFFFF);

    // count above the slot count enables all; ignore on top of a zero sum
    apply_settings(settings(1'b1, 4096, 4096, 4096, 5, 0, 7,
                            {16'hFFFF, 16'd5, 16'd2, 16'd1}));
    send_pair(16'hFFFF, 16'd5);
    send_pair(16'd2, 16'd1);
    send_pair(16'd5, 16'd5);
    send_pair(16'd7, 16'd9);

    // random settings, one phase with no idling on either side
    for (p = 0; p < RAND_PHASES; p++) begin
      apply_settings(pick_settings());
      steady = (p == 4);
      for (i = 0; i < PHASE_WORDS; i++) begin
        send_pair(pick_pixel(), pick_pixel());
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d pixel words over %0d register settings, sum and normalize.",
             words_checked, settings_used + 1);
    $display("%0d words ignored, %0d clamped, %0d mismatches.",
             ignored_seen, clamped_seen, fail_count);
    if (fail_count == 0 && in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
